[rtl/core/extent_block_translator_core_assert.svh]
// ----------------------------------------------------------------------------
// Extent block translator assertion macros
// Property wrappers on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef EXTENT_BLOCK_TRANSLATOR_CORE_ASSERT_SVH
`define EXTENT_BLOCK_TRANSLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EBT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ebt: same-cycle check failed");
`define EBT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ebt: next-cycle check failed");
`else
`define EBT_ASSERT_IMP(name, ante, cons)
`define EBT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/core/ebt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_pkg
// Shared types and constants of the extent block translator.
// ----------------------------------------------------------------------------
package ebt_pkg;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic REG_EXTENTS_IN_USE = 1'b0;

  localparam int BLOCK_W = 64;
  localparam int LEN_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;

  localparam int IDX_LSB   = 0;
  localparam int START_LSB = IDX_LSB + SLOT_W;
  localparam int LEN_LSB   = START_LSB + BLOCK_W;
  localparam int PHYS_LSB  = LEN_LSB + LEN_W;
  localparam int BLK_LSB   = PHYS_LSB + BLOCK_W;
  localparam int IN_BITS   = BLK_LSB + BLOCK_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [BLOCK_W-1:0] phys;
    logic [LEN_W-1:0]   len;
    logic [BLOCK_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic write;
    logic start;
    logic issue;
    logic capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic last_idx;
    logic hit;
    logic miss_last;
    logic out_free;
  } status_t;

endpackage

[rtl/core/ebt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_ctrl
// Sequencer: takes requests, runs the table scan, hands off the result.
// ----------------------------------------------------------------------------
module ebt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_func,
  output logic             s_tready,
  input  ebt_pkg::status_t st,
  output ebt_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DELIVER
  } state_t;

  state_t state;
  state_t state_next;
  logic   issued_all;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          if (s_func == ebt_pkg::FUNC_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = st.limit_zero ? DELIVER : SCAN;
          end
        end
      end
      SCAN: begin
        cmd.issue = !issued_all;
        if (st.hit) begin
          cmd.capture = 1'b1;
          state_next  = DELIVER;
        end else if (st.miss_last) begin
          state_next = DELIVER;
        end
      end
      DELIVER: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      issued_all <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        issued_all <= 1'b0;
      end else if (cmd.issue && st.last_idx) begin
        issued_all <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/ebt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_datapath
// Extent table memory, scan pipeline, range check and result registers.
// ----------------------------------------------------------------------------
module ebt_datapath #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ebt_pkg::cmd_t                 cmd,
  output ebt_pkg::status_t              st,
  input  logic [ebt_pkg::SLOT_W-1:0]    entry_index,
  input  logic [ebt_pkg::BLOCK_W-1:0]   entry_logical_start,
  input  logic [ebt_pkg::LEN_W-1:0]     entry_length,
  input  logic [ebt_pkg::BLOCK_W-1:0]   entry_physical_start,
  input  logic [ebt_pkg::BLOCK_W-1:0]   lookup_block,
  input  logic [ebt_pkg::COUNT_W-1:0]   extents_in_use,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ebt_pkg::BLOCK_W-1:0]   out_phys,
  output logic                          out_mapped
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int LIM_W = (CNT_W > ebt_pkg::COUNT_W) ? CNT_W : ebt_pkg::COUNT_W;
  localparam int WA_W  = IDX_W + ebt_pkg::SLOT_W;

  ebt_pkg::entry_t mem [TABLE_ENTRIES];

  logic [LIM_W-1:0]            cfg_ext;
  logic [LIM_W-1:0]            limit;
  logic [WA_W-1:0]             slot_ext;
  logic                        slot_ok;
  logic [IDX_W-1:0]            idx;
  logic [ebt_pkg::BLOCK_W-1:0] blk;

  logic                        a_valid;
  logic                        a_last;
  ebt_pkg::entry_t             a_entry;

  logic                        b_valid;
  logic                        b_last;
  logic                        b_borrow;
  logic [ebt_pkg::BLOCK_W-1:0] b_diff;
  logic [ebt_pkg::LEN_W-1:0]   b_len;
  logic [ebt_pkg::BLOCK_W-1:0] b_phys;
  logic [ebt_pkg::BLOCK_W:0]   diff_full;
  logic                        hit;

  logic [ebt_pkg::BLOCK_W-1:0] res_phys;
  logic                        res_mapped;

  assign cfg_ext  = LIM_W'(extents_in_use);
  assign limit    = (cfg_ext > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES) : cfg_ext;
  assign slot_ext = WA_W'(entry_index);
  assign slot_ok  = slot_ext < WA_W'(TABLE_ENTRIES);

  assign diff_full = {1'b0, blk} - {1'b0, a_entry.start};
  assign hit = b_valid && !b_borrow
            && (b_diff[ebt_pkg::BLOCK_W-1:ebt_pkg::LEN_W] == '0)
            && (b_diff[ebt_pkg::LEN_W-1:0] < b_len);

  assign st.limit_zero = (limit == '0);
  assign st.last_idx   = ((LIM_W'(idx) + LIM_W'(1)) == limit);
  assign st.hit        = hit;
  assign st.miss_last  = b_valid && b_last && !hit;
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[slot_ext[IDX_W-1:0]] <= '{phys:  entry_physical_start,
                                    len:   entry_length,
                                    start: entry_logical_start};
    end
    if (cmd.issue) begin
      a_entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      a_valid   <= 1'b0;
      a_last    <= 1'b0;
      b_valid   <= 1'b0;
      b_last    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx     <= '0;
        a_valid <= 1'b0;
        b_valid <= 1'b0;
      end else begin
        a_valid <= cmd.issue;
        b_valid <= a_valid;
        if (cmd.issue) begin
          idx    <= idx + IDX_W'(1);
          a_last <= st.last_idx;
        end
        b_last <= a_last;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk <= lookup_block;
    end
    b_borrow <= diff_full[ebt_pkg::BLOCK_W];
    b_diff   <= diff_full[ebt_pkg::BLOCK_W-1:0];
    b_len    <= a_entry.len;
    b_phys   <= a_entry.phys;
    if (cmd.start) begin
      res_phys   <= '0;
      res_mapped <= 1'b0;
    end else if (cmd.capture) begin
      res_phys   <= b_phys + b_diff;
      res_mapped <= 1'b1;
    end
    if (cmd.out_load) begin
      out_phys   <= res_phys;
      out_mapped <= res_mapped;
    end
  end

endmodule

[rtl/core/extent_block_translator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_block_translator_core
// Extent table with logical-to-physical block lookup.
// ----------------------------------------------------------------------------
// Load requests (tuser = 0) write one extent slot and give no result. Lookup
// requests (tuser = 1) scan the first min(extents_in_use, TABLE_ENTRIES) slots
// in order, one slot read per cycle from the single read port of the table
// memory, through a three-stage read/subtract/check pipeline; a lookup occupies
// the block until it has scanned up to and including the first hit (all scanned
// slots when none hits), and a lookup with no slots in use goes straight to its
// result; either is held longer while an earlier result still waits in the
// output register. Once the result is in the output register the next request
// is taken while it waits.
module extent_block_translator_core #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // entry_index, entry_logical_start, entry_length, entry_physical_start,
  // lookup_block, zero pad
  input  logic [ebt_pkg::IN_DATA_W-1:0] s_tdata,
  // func
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // physical_block
  output logic [ebt_pkg::BLOCK_W-1:0]   m_tdata,
  // mapped
  output logic                          m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

`include "extent_block_translator_core_assert.svh"

  ebt_pkg::cmd_t                 cmd;
  ebt_pkg::status_t              st;
  logic [ebt_pkg::COUNT_W-1:0]   extents_in_use;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[2] == ebt_pkg::REG_EXTENTS_IN_USE);
  assign prdata = (paddr[2] == ebt_pkg::REG_EXTENTS_IN_USE)
               ? {{(32 - ebt_pkg::COUNT_W){1'b0}}, extents_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      extents_in_use <= '0;
    end else if (cfg_wr) begin
      extents_in_use <= pwdata[ebt_pkg::COUNT_W-1:0];
    end
  end

  ebt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_func   (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ebt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .st                   (st),
    .entry_index          (s_tdata[ebt_pkg::START_LSB-1:ebt_pkg::IDX_LSB]),
    .entry_logical_start  (s_tdata[ebt_pkg::LEN_LSB-1:ebt_pkg::START_LSB]),
    .entry_length         (s_tdata[ebt_pkg::PHYS_LSB-1:ebt_pkg::LEN_LSB]),
    .entry_physical_start (s_tdata[ebt_pkg::BLK_LSB-1:ebt_pkg::PHYS_LSB]),
    .lookup_block         (s_tdata[ebt_pkg::IN_BITS-1:ebt_pkg::BLK_LSB]),
    .extents_in_use       (extents_in_use),
    .out_ready            (m_tready),
    .out_valid            (m_tvalid),
    .out_phys             (m_tdata),
    .out_mapped           (m_tuser)
  );

  `EBT_ASSERT_NEXT(a_cfg_write, cfg_wr, extents_in_use == $past(pwdata[ebt_pkg::COUNT_W-1:0]))
  `EBT_ASSERT_IMP(a_unmapped_zero, m_tvalid && !m_tuser, m_tdata == '0)
  `EBT_ASSERT_NEXT(a_lookup_busy, s_tvalid && s_tready && (s_tuser == ebt_pkg::FUNC_LOOKUP), !s_tready)

endmodule
